// ===== hdl/neuron_dot_product_activation_defines.svh =====
// Assertion macros used by the neuron datapath module
`ifndef NEURON_DOT_PRODUCT_ACTIVATION_DEFINES_SVH
`define NEURON_DOT_PRODUCT_ACTIVATION_DEFINES_SVH

// same-cycle implication
`define NDPA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ndpa check failed");

// next-cycle implication
`define NDPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ndpa check failed");

`endif

// ===== hdl/ndpa_pkg.sv =====
// Constants, register codes and exp table for the neuron datapath
package ndpa_pkg;

   localparam int MAX_INPUTS_DEF = 256;

   localparam int NUM_W   = 9;
   localparam int DATA_W  = 16;
   localparam int IDX_W   = 8;
   localparam int ACC_W   = 48;
   localparam int CSR_IDX_W = 2;

   localparam int EXP_STEPS = 17;
   localparam int DIV_STEPS = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_INPUTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARSE_RATE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_MODE    = 2'd3;

   localparam logic OP_WRITE_WEIGHT = 1'b0;
   localparam logic OP_FEED         = 1'b1;

   // exp(-2^n / 4096) in Q0.32, built by repeated rounded squaring
   function automatic logic [31:0] exp_tab_entry(input int n);
      logic [63:0] t;
      int          k;
      t = 64'd4293918848;
      for (k = 0; k < n; k++) begin
         t = (t * t + 64'h8000_0000) >> 32;
      end
      return t[31:0];
   endfunction

   localparam logic [31:0] EXP_TAB [EXP_STEPS] = '{
      exp_tab_entry(0),  exp_tab_entry(1),  exp_tab_entry(2),  exp_tab_entry(3),
      exp_tab_entry(4),  exp_tab_entry(5),  exp_tab_entry(6),  exp_tab_entry(7),
      exp_tab_entry(8),  exp_tab_entry(9),  exp_tab_entry(10), exp_tab_entry(11),
      exp_tab_entry(12), exp_tab_entry(13), exp_tab_entry(14), exp_tab_entry(15),
      exp_tab_entry(16)
   };

endpackage

// ===== hdl/neuron_dot_product_activation.sv =====
// Neuron: weight store, streaming MAC, shared-multiplier activation and sparsity average
//
//  channel   ports                                     direction  moves
//  request   start, busy, req_op, req_index, req_value in/out     weight write or input element
//  result    rsp_valid, rsp_response, rsp_sparsity     out        one word per evaluation
//  config    csr_write_en, csr_index, csr_write_data   in         register write
//
//  Weight writes and non-final elements leave busy low, so requests keep being accepted.
//  The final element raises busy for one MAC, one saturate, 17 steps of exp on the
//  shared 32x32 multiplier, one divider set-up, 15 restoring divide steps and the
//  sparsity update in S_RESP and S_SP2; the result word is strobed as busy falls.
//  Synchronous reset clears control, accumulator, count and sparsity average; the
//  weight store is not cleared. The result strobe lasts one cycle and cannot stall.
`include "neuron_dot_product_activation_defines.svh"

module neuron_dot_product_activation #(
   parameter int MAX_INPUTS = ndpa_pkg::MAX_INPUTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_op,
   input  logic [ndpa_pkg::IDX_W-1:0]             req_index,
   input  logic signed [ndpa_pkg::DATA_W-1:0]     req_value,
   output logic                                   rsp_valid,
   output logic signed [ndpa_pkg::DATA_W-1:0]     rsp_response,
   output logic signed [ndpa_pkg::DATA_W-1:0]     rsp_sparsity,
   input  logic                                   csr_write_en,
   input  logic [ndpa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ndpa_pkg::DATA_W-1:0]            csr_write_data
);

   localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int CW = $clog2(MAX_INPUTS + 1);
   localparam int LW = (CW > ndpa_pkg::NUM_W) ? CW : ndpa_pkg::NUM_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LAST   = 3'd1;
   localparam logic [2:0] S_SAT    = 3'd2;
   localparam logic [2:0] S_EXP    = 3'd3;
   localparam logic [2:0] S_DIVSET = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;
   localparam logic [2:0] S_SP2    = 3'd7;

   // configuration
   logic [ndpa_pkg::NUM_W-1:0]         num_inputs_ff;
   logic signed [ndpa_pkg::DATA_W-1:0] bias_ff;
   logic [ndpa_pkg::DATA_W-1:0]        sparse_rate_ff;
   logic                               act_mode_ff;

   // weight store
   logic signed [ndpa_pkg::DATA_W-1:0] weight_mem [MAX_INPUTS];
   logic signed [ndpa_pkg::DATA_W-1:0] w_ff;
   logic signed [ndpa_pkg::DATA_W-1:0] val_ff;
   logic                               badd_ff;
   logic                               mac_pend_ff;

   logic signed [ndpa_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [CW-1:0]                      count_ff, count_inc;
   logic [LW-1:0]                      limit;
   logic                               accept, accept_elem, accept_wr, last_elem;

   logic [2:0]                         state_ff, state_in;
   logic [4:0]                         step_ff;
   logic                               sig_ff, neg_ff;
   logic [16:0]                        a_ff;
   logic [31:0]                        r_ff;
   logic                               r_one_ff;
   logic [47:0]                        rem_ff, dsh_ff;
   logic [14:0]                        q_ff;
   logic signed [ndpa_pkg::DATA_W-1:0] resp_ff;
   logic signed [ndpa_pkg::DATA_W-1:0] sp_avg_ff;
   logic [32:0]                        spar_ff;
   logic                               rsp_valid_ff;

   // datapath nets
   logic signed [31:0]                 mac_prod;
   logic signed [27:0]                 bias_term;
   logic signed [48:0]                 acc_sum;
   logic signed [28:0]                 sat;
   logic [28:0]                        biased;
   logic [16:0]                        u17, mag;
   logic                               x_neg;
   logic [31:0]                        mul_a, mul_b;
   logic [63:0]                        mul_p;
   logic [31:0]                        mul_round;
   logic [32:0]                        e_val;
   logic [33:0]                        d_val;
   logic [46:0]                        num_val;
   logic [47:0]                        n_round;
   logic                               div_ge;
   logic [15:0]                        s_off, r_off;
   logic [16:0]                        one_minus_p;
   logic [32:0]                        sp_sum;
   logic [16:0]                        sp_u;

   assign accept      = start && !busy;
   assign accept_elem = accept && (req_op == ndpa_pkg::OP_FEED);
   assign accept_wr   = accept && (req_op == ndpa_pkg::OP_WRITE_WEIGHT);
   assign busy        = (state_ff != S_IDLE);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_response = resp_ff;
   assign rsp_sparsity = sp_avg_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_inputs_ff  <= ndpa_pkg::NUM_W'(256);
         bias_ff        <= '0;
         sparse_rate_ff <= '0;
         act_mode_ff    <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ndpa_pkg::CSR_NUM_INPUTS:  num_inputs_ff  <= csr_write_data[ndpa_pkg::NUM_W-1:0];
            ndpa_pkg::CSR_BIAS:        bias_ff        <= csr_write_data;
            ndpa_pkg::CSR_SPARSE_RATE: sparse_rate_ff <= csr_write_data;
            ndpa_pkg::CSR_ACT_MODE:    act_mode_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // element limit clamped to 1 .. MAX_INPUTS
   always_comb begin
      if (num_inputs_ff == '0) begin
         limit = LW'(1);
      end else if (32'(num_inputs_ff) > MAX_INPUTS) begin
         limit = LW'(MAX_INPUTS);
      end else begin
         limit = LW'(num_inputs_ff);
      end
   end

   assign count_inc = count_ff + CW'(1);
   assign last_elem = (LW'(count_inc) >= limit);

   // weight memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept_wr && (32'(req_index) < MAX_INPUTS)) begin
         weight_mem[AW'(req_index)] <= req_value;
      end
      if (accept_elem) begin
         w_ff    <= weight_mem[AW'(count_ff)];
         val_ff  <= req_value;
         badd_ff <= !act_mode_ff;
      end
   end

   // streaming MAC, one element behind the accept
   assign mac_prod  = w_ff * val_ff;
   assign bias_term = {bias_ff, 12'b0};

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == S_SAT) begin
         acc_in = '0;
      end else if (mac_pend_ff) begin
         acc_in = acc_ff + ndpa_pkg::ACC_W'(mac_prod)
                  + (badd_ff ? ndpa_pkg::ACC_W'(bias_term) : '0);
      end
   end

   // saturate to +/-8.0 and round to Q4.12
   always_comb begin
      acc_sum = 49'(acc_ff) + (sig_ff ? 49'(bias_term) : 49'sd0);
      if (acc_sum > 49'sd134217728) begin
         sat = 29'sd134217728;
      end else if (acc_sum < -49'sd134217728) begin
         sat = -29'sd134217728;
      end else begin
         sat = 29'(acc_sum);
      end
      biased = $unsigned(sat) + 29'd134219776;
      u17    = biased[28:12];
      x_neg  = (u17 < 17'd32768);
      mag    = x_neg ? (17'd32768 - u17) : (u17 - 17'd32768);
   end

   // shared multiplier
   assign s_off       = 16'(sp_avg_ff + 16'sd16384);
   assign r_off       = 16'(resp_ff + 16'sd16384);
   assign one_minus_p = 17'h10000 - {1'b0, sparse_rate_ff};

   always_comb begin
      unique case (state_ff)
         S_EXP: begin
            mul_a = r_ff;
            mul_b = ndpa_pkg::EXP_TAB[step_ff];
         end
         S_RESP: begin
            mul_a = 32'(s_off);
            mul_b = 32'(one_minus_p);
         end
         S_SP2: begin
            mul_a = 32'(sparse_rate_ff);
            mul_b = 32'(r_off);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p     = mul_a * mul_b;
   assign mul_round = 32'((mul_p + 64'h8000_0000) >> 32);

   // divider set-up
   always_comb begin
      e_val = r_one_ff ? 33'h1_0000_0000 : {1'b0, r_ff};
      d_val = 34'h1_0000_0000 + 34'(e_val);
      if (!sig_ff) begin
         num_val = 47'(33'h1_0000_0000 - e_val) << 14;
      end else if (!neg_ff) begin
         num_val = 47'h4000_0000_0000;
      end else begin
         num_val = 47'(e_val) << 14;
      end
      n_round = 48'(num_val) + 48'(d_val >> 1);
   end

   assign div_ge = (rem_ff >= dsh_ff);

   // sparsity: offset operands keep both products unsigned
   assign sp_sum = spar_ff + 33'(mul_p) + 33'd32768;
   assign sp_u   = sp_sum[32:16];

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept_elem && last_elem) state_in = S_LAST;
         S_LAST:   state_in = S_SAT;
         S_SAT:    state_in = S_EXP;
         S_EXP:    if (step_ff == 5'(ndpa_pkg::EXP_STEPS - 1)) state_in = S_DIVSET;
         S_DIVSET: state_in = S_DIV;
         S_DIV:    if (step_ff == 5'(ndpa_pkg::DIV_STEPS - 1)) state_in = S_RESP;
         S_RESP:   state_in = S_SP2;
         S_SP2:    state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mac_pend_ff  <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         sp_avg_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         mac_pend_ff  <= accept_elem;
         acc_ff       <= acc_in;
         rsp_valid_ff <= (state_ff == S_SP2);
         if (accept_elem) begin
            count_ff <= last_elem ? '0 : count_inc;
         end
         if (state_ff == S_SP2) begin
            sp_avg_ff <= 16'(sp_u - 17'd16384);
         end
         if ((state_ff == S_EXP && step_ff != 5'(ndpa_pkg::EXP_STEPS - 1)) ||
             (state_ff == S_DIV && step_ff != 5'(ndpa_pkg::DIV_STEPS - 1))) begin
            step_ff <= step_ff + 5'd1;
         end else begin
            step_ff <= '0;
         end
      end
   end

   // activation datapath registers
   always_ff @(posedge clock) begin
      if (accept_elem && last_elem) begin
         sig_ff <= act_mode_ff;
      end
      unique case (state_ff)
         S_SAT: begin
            neg_ff   <= x_neg;
            a_ff     <= sig_ff ? mag : 17'(mag << 1);
            r_one_ff <= 1'b1;
         end
         S_EXP: begin
            if (a_ff[step_ff]) begin
               r_ff     <= r_one_ff ? ndpa_pkg::EXP_TAB[step_ff] : mul_round;
               r_one_ff <= 1'b0;
            end
         end
         S_DIVSET: begin
            rem_ff <= n_round;
            dsh_ff <= 48'(d_val) << 14;
            q_ff   <= '0;
         end
         S_DIV: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            dsh_ff <= dsh_ff >> 1;
            q_ff   <= {q_ff[13:0], div_ge};
         end
         S_RESP: begin
            resp_ff <= (neg_ff && !sig_ff) ? -16'sd0 - 16'($signed({1'b0, q_ff}))
                                           : 16'($signed({1'b0, q_ff}));
            spar_ff <= 33'(mul_p);
         end
         default: ;
      endcase
   end

   `NDPA_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, 32'(count_ff) < MAX_INPUTS)
   `NDPA_ASSERT_NEXT(a_last_busy, clock, reset, accept_elem && last_elem, busy)
   `NDPA_ASSERT_IMPL(a_quot_bound, clock, reset, state_ff == S_RESP, q_ff <= 15'd16384)
   `NDPA_ASSERT_IMPL(a_rsp_src, clock, reset, rsp_valid_ff, $past(state_ff) == S_SP2)
   `NDPA_ASSERT_IMPL(a_mac_when, clock, reset, mac_pend_ff, state_ff == S_IDLE || state_ff == S_LAST)

endmodule
